// File: hw/rtl/solp_pkg.sv
// shared constants and types for the second-order low-pass filter
package solp_pkg;

  // default sample width and coefficient fraction bits
  localparam int SAMPLE_WIDTH_DEF   = 16;
  localparam int COEF_FRAC_BITS_DEF = 16;

  // fraction bits of the output history (Q S.16)
  localparam int HIST_FRAC = 16;

  // startup counter: the filter law applies once two samples have been seen
  localparam int          STARTUP_W    = 2;
  localparam logic [1:0]  STARTUP_DONE = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN = 2'd0,
    CFG_FB1  = 2'd1,
    CFG_FB2  = 2'd2
  } cfg_idx_t;

endpackage

// File: hw/rtl/second_order_lowpass_iir.sv
// top level of the second-order low-pass iir filter
//
// input channel: in_valid / in_stall with one signed sample per transaction
// on in_sample_in. result channel: out_valid / out_stall with one filtered
// sample per transaction on out_filtered_out. a transaction completes at a
// rising edge with valid high and stall low.
// the three coefficients are written through cfg_we / cfg_index / cfg_wdata
// while the filter is idle; index 0 is the gain, 1 and 2 the feedback terms.
// the input register passes a sample into the result register, with out_valid
// high, unless out_stall holds it (one input register, one result register).
// throughput: one sample per cycle while out_stall stays low; the feedback
// path through the two multiply-accumulate terms closes within the single
// combinational stage between the input register and the result register.
// reset (rst_n low, synchronous) clears the coefficients, the input and
// output history and the startup counter; the first two samples after reset
// pass through unfiltered.
// when the receiver stalls, the result register holds its sample and the
// input register keeps one more; in_stall rises once both are full.
module second_order_lowpass_iir import solp_pkg::*; #(
  parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]  in_sample_in,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]  out_filtered_out,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [CFG_IDX_W-1:0]            cfg_index,
  input  logic [COEF_FRAC_BITS+1:0]       cfg_wdata
);

  logic [COEF_FRAC_BITS-1:0]        coef_gain;
  logic signed [COEF_FRAC_BITS+1:0] coef_fb1;
  logic signed [COEF_FRAC_BITS:0]   coef_fb2;

  // input register
  logic                           stg_valid_r, stg_valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] stg_sample_r;

  // result register
  logic                           out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] out_filtered_r;

  logic                           in_accept;
  logic                           advance;
  logic signed [SAMPLE_WIDTH-1:0] core_filtered;

  solp_cfg_regs #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .coef_gain (coef_gain),
    .coef_fb1  (coef_fb1),
    .coef_fb2  (coef_fb2)
  );

  // history advances exactly when the staged sample moves into the result register
  solp_core #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .sample    (stg_sample_r),
    .coef_gain (coef_gain),
    .coef_fb1  (coef_fb1),
    .coef_fb2  (coef_fb2),
    .filtered  (core_filtered)
  );

  // handshake control
  always_comb begin
    advance   = stg_valid_r && (!out_valid_r || !out_stall);
    in_stall  = stg_valid_r && !advance;
    in_accept = in_valid && !in_stall;

    if (in_accept) begin
      stg_valid_nxt = 1'b1;
    end else if (advance) begin
      stg_valid_nxt = 1'b0;
    end else begin
      stg_valid_nxt = stg_valid_r;
    end

    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_accept) begin
      stg_sample_r <= in_sample_in;
    end
    if (advance) begin
      out_filtered_r <= core_filtered;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_filtered_out = out_filtered_r;

endmodule

// File: hw/rtl/solp_cfg_regs.sv
// coefficient registers written through the configuration port
module solp_cfg_regs import solp_pkg::*; #(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [COEF_FRAC_BITS+1:0]     cfg_wdata,
  output logic [COEF_FRAC_BITS-1:0]     coef_gain,
  output logic signed [COEF_FRAC_BITS+1:0] coef_fb1,
  output logic signed [COEF_FRAC_BITS:0]   coef_fb2
);

  logic [COEF_FRAC_BITS-1:0]        coef_gain_r;
  logic signed [COEF_FRAC_BITS+1:0] coef_fb1_r;
  logic signed [COEF_FRAC_BITS:0]   coef_fb2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_gain_r <= '0;
      coef_fb1_r  <= '0;
      coef_fb2_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GAIN: coef_gain_r <= cfg_wdata[COEF_FRAC_BITS-1:0];
        CFG_FB1:  coef_fb1_r  <= $signed(cfg_wdata);
        CFG_FB2:  coef_fb2_r  <= $signed(cfg_wdata[COEF_FRAC_BITS:0]);
        default: begin
          // unused index, write dropped
        end
      endcase
    end
  end

  assign coef_gain = coef_gain_r;
  assign coef_fb1  = coef_fb1_r;
  assign coef_fb2  = coef_fb2_r;

endmodule

// File: hw/rtl/solp_core.sv
// filter arithmetic with input and output history
module solp_core import solp_pkg::*; #(
  parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step,
  input  logic signed [SAMPLE_WIDTH-1:0]    sample,
  input  logic [COEF_FRAC_BITS-1:0]         coef_gain,
  input  logic signed [COEF_FRAC_BITS+1:0]  coef_fb1,
  input  logic signed [COEF_FRAC_BITS:0]    coef_fb2,
  output logic signed [SAMPLE_WIDTH-1:0]    filtered
);

  localparam int HW     = SAMPLE_WIDTH + HIST_FRAC;
  localparam int XS_W   = SAMPLE_WIDTH + 2;
  localparam int PG_W   = XS_W + COEF_FRAC_BITS + 1;
  localparam int P1_W   = COEF_FRAC_BITS + 2 + HW;
  localparam int P2_W   = COEF_FRAC_BITS + 1 + HW;
  localparam int ACC_W  = SAMPLE_WIDTH + COEF_FRAC_BITS + 21;
  localparam int SH_W   = ACC_W - COEF_FRAC_BITS;
  localparam int OE_W   = HW + 1;
  localparam int OS_W   = SAMPLE_WIDTH + 1;

  localparam logic signed [ACC_W-1:0] ACC_RND  = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [SH_W-1:0]  HIST_MAX = (SH_W'(1) <<< (HW - 1)) - SH_W'(1);
  localparam logic signed [SH_W-1:0]  HIST_MIN = -(SH_W'(1) <<< (HW - 1));
  localparam logic signed [OE_W-1:0]  OUT_RND  = OE_W'(1) <<< (HIST_FRAC - 1);
  localparam logic signed [OS_W-1:0]  OUT_MAX  = (OS_W'(1) <<< (SAMPLE_WIDTH - 1)) - OS_W'(1);
  localparam logic signed [OS_W-1:0]  OUT_MIN  = -(OS_W'(1) <<< (SAMPLE_WIDTH - 1));

  logic signed [SAMPLE_WIDTH-1:0] x1_r, x2_r;
  logic signed [HW-1:0]           y1_r, y2_r;
  logic [STARTUP_W-1:0]           startup_r;
  logic [STARTUP_W-1:0]           startup_nxt;

  logic signed [XS_W-1:0]  xs;
  logic signed [PG_W-1:0]  prod_g;
  logic signed [P1_W-1:0]  prod_1;
  logic signed [P2_W-1:0]  prod_2;
  logic signed [ACC_W-1:0] acc;
  logic signed [SH_W-1:0]  acc_sh;
  logic signed [HW-1:0]    y_sat;
  logic signed [HW-1:0]    y_new;
  logic signed [OE_W-1:0]  o_ext;
  logic signed [OS_W-1:0]  o_sh;

  always_comb begin
    xs     = XS_W'(sample) + (XS_W'(x1_r) <<< 1) + XS_W'(x2_r);
    prod_g = PG_W'(xs) * PG_W'($signed({1'b0, coef_gain}));
    prod_1 = P1_W'(coef_fb1) * P1_W'(y1_r);
    prod_2 = P2_W'(coef_fb2) * P2_W'(y2_r);
    acc    = (ACC_W'(prod_g) <<< HIST_FRAC) + ACC_W'(prod_1) + ACC_W'(prod_2) + ACC_RND;
    acc_sh = SH_W'(acc >>> COEF_FRAC_BITS);

    // saturate to the history range
    if (acc_sh > HIST_MAX) begin
      y_sat = HIST_MAX[HW-1:0];
    end else if (acc_sh < HIST_MIN) begin
      y_sat = HIST_MIN[HW-1:0];
    end else begin
      y_sat = acc_sh[HW-1:0];
    end

    // first two samples pass straight through
    if (startup_r < STARTUP_DONE) begin
      y_new       = {sample, {HIST_FRAC{1'b0}}};
      startup_nxt = startup_r + STARTUP_W'(1);
    end else begin
      y_new       = y_sat;
      startup_nxt = startup_r;
    end

    // round to integer and saturate to the sample range
    o_ext = OE_W'(y_new) + OUT_RND;
    o_sh  = OS_W'(o_ext >>> HIST_FRAC);
    if (o_sh > OUT_MAX) begin
      filtered = OUT_MAX[SAMPLE_WIDTH-1:0];
    end else if (o_sh < OUT_MIN) begin
      filtered = OUT_MIN[SAMPLE_WIDTH-1:0];
    end else begin
      filtered = o_sh[SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_r      <= '0;
      x2_r      <= '0;
      y1_r      <= '0;
      y2_r      <= '0;
      startup_r <= '0;
    end else if (step) begin
      x2_r      <= x1_r;
      x1_r      <= sample;
      y2_r      <= y1_r;
      y1_r      <= y_new;
      startup_r <= startup_nxt;
    end
  end

endmodule

// File: tb/tb_second_order_lowpass_iir.sv
// self-checking testbench for the second-order low-pass iir filter: directed table, then random
`timescale 1ns / 100ps

module tb_second_order_lowpass_iir;
  import solp_pkg::*;

  localparam int SW = SAMPLE_WIDTH_DEF;
  localparam int CF = COEF_FRAC_BITS_DEF;
  localparam int CW = COEF_FRAC_BITS_DEF + 2;

  // index with no register behind it, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // history in Q S.16, output as a plain sample, both saturated
  localparam longint HIST_MAX = (longint'(1) <<< (SW - 1 + HIST_FRAC)) - 1;
  localparam longint HIST_MIN = -(longint'(1) <<< (SW - 1 + HIST_FRAC));
  localparam longint SAMP_MAX = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint SAMP_MIN = -(longint'(1) <<< (SW - 1));

  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;

  logic                  clk;
  logic                  rst_n        = 1'b0;
  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  logic signed [SW-1:0]  in_sample_in = '0;
  logic                  out_valid;
  logic                  out_stall    = 1'b0;
  logic signed [SW-1:0]  out_filtered_out;
  logic                  cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CW-1:0]         cfg_wdata    = '0;

  second_order_lowpass_iir dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_in     (in_sample_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_filtered_out (out_filtered_out),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // filter predictor: its own copy of coefficients and history
  // ---------------------------------------------------------------------------
  longint               gain_coef  = 0;   // unsigned Q0.16
  longint               fb1_coef   = 0;   // signed Q2.16
  longint               fb2_coef   = 0;   // signed Q1.16
  logic signed [SW-1:0] x_prev1    = '0;
  logic signed [SW-1:0] x_prev2    = '0;
  longint               y_prev1    = 0;   // Q S.16
  longint               y_prev2    = 0;
  logic [STARTUP_W-1:0] warm_count = '0;

  function automatic logic signed [SW-1:0] filter_predict(input logic signed [SW-1:0] x);
    longint acc;
    longint hist;
    longint rounded;
    if (warm_count < STARTUP_DONE) begin
      // first samples after reset pass straight through
      hist = longint'(x) <<< HIST_FRAC;
      warm_count = warm_count + 1'b1;
    end else begin
      // exact accumulator with CF + 16 fraction bits
      acc = (gain_coef * (longint'(x) + 2 * longint'(x_prev1) + longint'(x_prev2)))
            <<< HIST_FRAC;
      acc = acc + fb1_coef * y_prev1 + fb2_coef * y_prev2;
      acc = acc + (longint'(1) <<< (CF - 1));
      hist = acc >>> CF;
      if (hist > HIST_MAX) hist = HIST_MAX;
      else if (hist < HIST_MIN) hist = HIST_MIN;
    end
    rounded = (hist + (longint'(1) <<< (HIST_FRAC - 1))) >>> HIST_FRAC;
    if (rounded > SAMP_MAX) rounded = SAMP_MAX;
    else if (rounded < SAMP_MIN) rounded = SAMP_MIN;
    y_prev2 = y_prev1;
    y_prev1 = hist;
    x_prev2 = x_prev1;
    x_prev1 = x;
    return SW'(rounded);
  endfunction

  // ---------------------------------------------------------------------------
  // expected filtered samples, oldest first, and the result checker
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] pending_filtered[$];
  logic signed [SW-1:0] want_sample;
  int                   mismatch_count = 0;
  int unsigned          send_idle_pct  = 0;
  int unsigned          recv_stall_pct = 0;

  // outputs are read right after the edge, so they still hold the values
  // that decided the transaction at that edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_filtered.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result transaction: got %0d", out_filtered_out);
      end else begin
        want_sample = pending_filtered.pop_front();
        if (out_filtered_out !== want_sample) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("filtered_out mismatch: expected %0d, got %0d",
                     want_sample, out_filtered_out);
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // watchdog on total run length
  int cycle_count = 0;
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one input transaction; a typed-in result replaces the predicted one
  task automatic drive_sample(input logic signed [SW-1:0] smp, input logic known,
                              input logic signed [SW-1:0] typed);
    logic signed [SW-1:0] predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= smp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = filter_predict(smp);
    pending_filtered.push_back(known ? typed : predicted);
  endtask

  // coefficients change only once the filter has drained
  task automatic program_coefs(input logic [CW-1:0] gain_w, input logic [CW-1:0] fb1_w,
                               input logic [CW-1:0] fb2_w);
    in_valid <= 1'b0;
    while (pending_filtered.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_GAIN;
    cfg_wdata <= gain_w;
    @(posedge clk);
    cfg_index <= CFG_FB1;
    cfg_wdata <= fb1_w;
    @(posedge clk);
    cfg_index <= CFG_FB2;
    cfg_wdata <= fb2_w;
    @(posedge clk);
    cfg_index <= CFG_UNUSED;
    cfg_wdata <= CW'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    // only the low bits of the gain and second feedback registers take effect
    gain_coef = longint'(gain_w[CF-1:0]);
    fb1_coef  = longint'(signed'(fb1_w));
    fb2_coef  = longint'(signed'(fb2_w[CF:0]));
  endtask

  // ---------------------------------------------------------------------------
  // directed table: coefficient rows carry a write, sample rows one transaction
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic          cfg_row;
    logic [CW-1:0] gain_w;
    logic [CW-1:0] fb1_w;
    logic [CW-1:0] fb2_w;
    logic [SW-1:0] smp;
    logic          known;
    logic [SW-1:0] result;
  } dir_row_t;

  localparam int DIR_ROWS = 29;

  dir_row_t dir_table [DIR_ROWS] = '{
    // startup: the first two samples come back unchanged
    '{1'b0, 18'h0, 18'h0, 18'h0, 16'h8000, 1'b1, 16'h8000},
    '{1'b0, 18'h0, 18'h0, 18'h0, 16'h7FFF, 1'b1, 16'h7FFF},
    // reset coefficients are zero, so the filter outputs zero
    '{1'b0, 18'h0, 18'h0, 18'h0, 16'h0000, 1'b1, 16'h0000},
    '{1'b0, 18'h0, 18'h0, 18'h0, 16'h7FFF, 1'b1, 16'h0000},
    '{1'b0, 18'h0, 18'h0, 18'h0, 16'h8000, 1'b1, 16'h0000},
    // full gain, no feedback: runs of extremes saturate
    '{1'b1, 18'h0FFFF, 18'h0, 18'h0, 16'h0, 1'b0, 16'h0},
    '{1'b0, 18'h0, 18'h0, 18'h0, 16'h7FFF, 1'b0, 16'h0000},
    '{1'b0, 18'h0, 18'h0, 18'h0, 16'h7FFF, 1'b0, 16'h0000},
    '{1'b0, 18'h0, 18'h0, 18'h0, 16'h7FFF, 1'b1, 16'h7FFF},
    '{1'b0, 18'h0, 18'h0, 18'h0, 16'h8000, 1'b0, 16'h0000},
    '{1'b0, 18'h0, 18'h0, 18'h0, 16'h8000, 1'b0, 16'h0000},
    '{1'b0, 18'h0, 18'h0, 18'h0, 16'h8000, 1'b1, 16'h8000},
    // largest positive f1: runaway feedback, saturated history
    '{1'b1, 18'h0, 18'h1FFFF, 18'h0, 16'h0, 1'b0, 16'h0},
    '{1'b0, 18'h0, 18'h0, 18'h0, 16'h0001, 1'b0, 16'h0000},
    '{1'b0, 18'h0, 18'h0, 18'h0, 16'hFFFF, 1'b0, 16'h0000},
    '{1'b0, 18'h0, 18'h0, 18'h0, 16'h3039, 1'b0, 16'h0000},
    // most negative f1 and f2: oscillating feedback
    '{1'b1, 18'h0, 18'h20000, 18'h30000, 16'h0, 1'b0, 16'h0},
    '{1'b0, 18'h0, 18'h0, 18'h0, 16'h0000, 1'b0, 16'h0000},
    '{1'b0, 18'h0, 18'h0, 18'h0, 16'h7FFF, 1'b0, 16'h0000},
    '{1'b0, 18'h0, 18'h0, 18'h0, 16'h8000, 1'b0, 16'h0000},
    // f2 outside its range, top write bit must be dropped, leaving a positive f2
    '{1'b1, 18'h0, 18'h0, 18'h2FFFF, 16'h0, 1'b0, 16'h0},
    '{1'b0, 18'h0, 18'h0, 18'h0, 16'h5555, 1'b0, 16'h0000},
    '{1'b0, 18'h0, 18'h0, 18'h0, 16'hAAAA, 1'b0, 16'h0000},
    // realistic double pole at 0.8, gain write with unused high bits set
    '{1'b1, 18'h30A3D, 18'h1999A, 18'h35C29, 16'h0, 1'b0, 16'h0},
    '{1'b0, 18'h0, 18'h0, 18'h0, 16'h2710, 1'b0, 16'h0000},
    '{1'b0, 18'h0, 18'h0, 18'h0, 16'h2710, 1'b0, 16'h0000},
    '{1'b0, 18'h0, 18'h0, 18'h0, 16'h2710, 1'b0, 16'h0000},
    '{1'b0, 18'h0, 18'h0, 18'h0, 16'h2710, 1'b0, 16'h0000},
    '{1'b0, 18'h0, 18'h0, 18'h0, 16'h2710, 1'b0, 16'h0000}
  };

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int                   sel;
    int                   walk_level;
    int                   pole_q;
    longint               pole;
    logic [CW-1:0]        gain_w;
    logic [CW-1:0]        fb1_w;
    logic [CW-1:0]        fb2_w;
    logic signed [SW-1:0] smp;

    walk_level = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_table[r].cfg_row)
        program_coefs(dir_table[r].gain_w, dir_table[r].fb1_w, dir_table[r].fb2_w);
      else
        drive_sample(dir_table[r].smp, dir_table[r].known, dir_table[r].result);
    end

    // phases: no idling, idle sender, stalling receiver, light idling on both
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 80 : (phase == 3) ? 6 : 0;
      recv_stall_pct = (phase == 2) ? 80 : (phase == 3) ? 6 : 0;
      for (int blk = 0; blk < 4; blk++) begin
        case ($urandom_range(3))
          0: begin
            // stable low-pass with unity dc gain, double pole between -64880/65536 and 64880/65536
            pole_q = int'($urandom_range(129760)) - 64880;
            pole   = longint'(pole_q);
            gain_w = CW'(((65536 - pole) * (65536 - pole)) >>> 18);
            fb1_w  = CW'(2 * pole);
            fb2_w  = CW'(-((pole * pole) >>> 16));
          end
          1: begin
            // arbitrary bit patterns, out-of-range values included
            gain_w = CW'($urandom);
            fb1_w  = CW'($urandom);
            fb2_w  = CW'($urandom);
          end
          2: begin
            gain_w = $urandom_range(1) ? 18'h0FFFF : 18'h00000;
            fb1_w  = $urandom_range(1) ? 18'h1FFFF : 18'h20000;
            fb2_w  = $urandom_range(1) ? 18'h30000 : 18'h00000;
          end
          default: begin
            gain_w = CW'($urandom_range(65535));
            fb1_w  = CW'(int'($urandom_range(262143)) - 131072);
            fb2_w  = CW'(-int'($urandom_range(65536)));
          end
        endcase
        program_coefs(gain_w, fb1_w, fb2_w);

        for (int n = 0; n < 100; n++) begin
          sel = $urandom_range(99);
          if (sel < 40) begin
            smp = SW'($urandom);
          end else if (sel < 55) begin
            case ($urandom_range(3))
              0: smp = 16'h8000;
              1: smp = 16'h7FFF;
              2: smp = 16'h0000;
              default: smp = 16'hFFFF;
            endcase
          end else if (sel < 80) begin
            smp = SW'(int'($urandom_range(511)) - 256);
          end else begin
            // slowly wandering signal, the kind the filter is meant for
            walk_level = walk_level + int'($urandom_range(4096)) - 2048;
            if (walk_level > 32767) walk_level = 32767;
            if (walk_level < -32768) walk_level = -32768;
            smp = SW'(walk_level);
          end
          drive_sample(smp, 1'b0, '0);
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_filtered.size() != 0) @(posedge clk);
    // then keep watching to catch any stray result
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_filtered.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
